/* sv/assert_macros.svh */
// Assertion macros shared by the subcode Q generator modules.
// Each macro clocks on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CSQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CSQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/csq_pkg.sv */
// Shared types, constants and helper functions of the subcode Q generator.
// No dependencies; the design modules and the testbench import this package.
package csq_pkg;

    localparam int TRACK_SLOTS_DEF = 99;
    localparam int CFG_IDX_W       = 4;
    localparam int QUEUE_DEPTH     = 2;
    localparam int Q_BYTES         = 12;
    localparam int DIV_W           = 21;
    localparam int REM_W           = 7;
    localparam int FRAMES_PER_SEC  = 75;
    localparam int SECS_PER_MIN    = 60;
    localparam int LEAD_IN_SECTORS = 150;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_TRACK  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRACK_COUNT = 4'd1;

    // Q frame constants.
    localparam logic [3:0] ADR_MODE1   = 4'h1;
    localparam logic [7:0] SUB_PAUSE   = 8'h80;
    localparam logic [7:0] SUB_Q       = 8'h40;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    typedef struct packed {
        logic [6:0] base_track;
        logic [6:0] track_count;
    } csq_cfg_t;

    typedef struct packed {
        logic signed [19:0] start;
        logic [18:0]        length;
        logic [18:0]        pregap;
        logic [3:0]         control;
    } csq_entry_t;

    // Classified item passed from the front to the back through the queue.
    typedef struct packed {
        logic               is_query;
        logic               slot_ok;
        logic [6:0]         slot;
        csq_entry_t         entry;
        logic signed [19:0] lba;
    } csq_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_LOAD_RD,
        ST_LOAD_CHK,
        ST_PREV_RD,
        ST_PREV_CHK,
        ST_DIV,
        ST_CRC,
        ST_EMIT
    } csq_state_t;

    // Binary to BCD of the low byte; values above 99 wrap in the tens digit.
    function automatic logic [7:0] to_bcd(input logic [7:0] v);
        logic [15:0] prod;
        logic [4:0]  tens;
        logic [7:0]  ones;
        prod = {8'd0, v} * 16'd205;
        tens = prod[15:11];
        ones = v - 8'({3'd0, tens} * 8'd10);
        return {tens[3:0], ones[3:0]};
    endfunction

    // One byte of the CRC-16 with polynomial 0x1021, MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'd0};
        for (int k = 0; k < 8; k++) begin
            r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
        end
        return r;
    endfunction

endpackage

/* sv/csq_if.sv */
// Channel interfaces of the subcode Q generator: request, response, config.
// No dependencies; the register index width is written out as four bits.
interface csq_req_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic [6:0]         track_number;
    logic signed [19:0] track_start;
    logic [18:0]        track_length;
    logic [18:0]        pregap_length;
    logic [3:0]         track_control;
    logic signed [19:0] sector_address;

    modport source (output valid, op, track_number, track_start, track_length,
                    pregap_length, track_control, sector_address, input ready);
    modport sink (input valid, op, track_number, track_start, track_length,
                  pregap_length, track_control, sector_address, output ready);
endinterface

interface csq_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  q_byte;
    logic [63:0] sub_bytes;
    logic        pause;
    logic        track_missing;
    logic        last;

    modport source (output valid, q_byte, sub_bytes, pause, track_missing, last,
                    input ready);
    modport sink (input valid, q_byte, sub_bytes, pause, track_missing, last,
                  output ready);
endinterface

interface csq_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] index;
    logic [6:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* sv/csq_front.sv */
// Front end: holds the configuration registers, accepts request transactions
// and classifies them for the queue. Depends on csq_pkg and csq_if.
module csq_front
    import csq_pkg::*;
#(
    parameter int TRACK_SLOTS = TRACK_SLOTS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    csq_cfg_if.sink    cfg,
    csq_req_if.sink    req,
    input  logic       q_full,
    output logic       q_push,
    output csq_item_t  q_item,
    output csq_cfg_t   cfg_val
);

    logic [6:0] first_reg;
    logic [6:0] count_reg;

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 7'd1;
            count_reg <= 7'd0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_BASE_TRACK:  first_reg <= cfg.data;
                CFG_TRACK_COUNT: count_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign cfg_val.base_track  = first_reg;
    assign cfg_val.track_count = count_reg;

    // Accept while the queue has room.
    assign req.ready = !q_full;
    assign q_push    = req.valid && !q_full;

    // Classify: operation and whether the written slot exists.
    always_comb
    begin
        q_item.is_query      = req.op;
        q_item.slot_ok       = (req.track_number != 7'd0) &&
                               (req.track_number <= 7'(TRACK_SLOTS));
        q_item.slot          = req.track_number - 7'd1;
        q_item.entry.start   = req.track_start;
        q_item.entry.length  = req.track_length;
        q_item.entry.pregap  = req.pregap_length;
        q_item.entry.control = req.track_control;
        q_item.lba           = req.sector_address;
    end

endmodule

/* sv/csq_queue.sv */
// Short queue of classified items between the front and the back.
// Depends on csq_pkg for the item type and depth.
module csq_queue
    import csq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  csq_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      head_valid,
    output csq_item_t head_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    csq_item_t          slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;

    assign full       = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = slots_reg[rd_ptr_reg];

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // Payload storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_item;
    end

endmodule

/* sv/csq_back.sv */
// Back end: track table memory, track search, MSF divider, CRC and the
// twelve-beat response output. Depends on csq_pkg, csq_if, assert_macros.svh.
`include "assert_macros.svh"
module csq_back
    import csq_pkg::*;
#(
    parameter int TRACK_SLOTS = TRACK_SLOTS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  csq_cfg_t  cfg_val,
    input  logic      head_valid,
    input  csq_item_t head_item,
    output logic      pop,
    csq_rsp_if.source rsp
);

    localparam int SLOT_W = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;

    csq_state_t state_reg, state_next;

    csq_entry_t         mem [TRACK_SLOTS];
    csq_entry_t         rd_data_reg;
    logic               rd_ok_reg;

    logic signed [19:0] lba_reg;
    logic [7:0]         trk_reg;
    logic [7:0]         end_reg;
    logic               found_reg;
    csq_entry_t         ent_reg;
    logic [3:0]         ctrl_reg;
    logic               pause_reg;
    logic               index1_reg;
    logic [DIV_W-1:0]   ab_reg;
    logic [DIV_W-1:0]   num_reg;
    logic [14:0]        quo_reg;
    logic [2:0]         step_reg;
    logic [7:0]         rel_m_reg, rel_s_reg, rel_f_reg;
    logic [7:0]         ab_m_reg, ab_s_reg, ab_f_reg;
    logic [15:0]        crc_reg;
    logic [3:0]         idx_reg;

    logic               out_valid_reg;
    logic [7:0]         out_q_reg;
    logic [63:0]        out_sub_reg;
    logic               out_pause_reg;
    logic               out_missing_reg;
    logic               out_last_reg;

    logic               mem_we;
    logic               rd_en;
    logic [7:0]         rd_trk;
    logic [7:0]         rd_idx;
    logic               rd_in_range;
    logic               out_load;

    // Memory read port: out-of-range tracks read as an all-zero entry.
    assign rd_idx      = rd_trk - 8'd1;
    assign rd_in_range = (rd_trk != 8'd0) && (rd_trk <= 8'(TRACK_SLOTS));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[head_item.slot[SLOT_W-1:0]] <= head_item.entry;
        if (rd_en && rd_in_range)
            rd_data_reg <= mem[rd_idx[SLOT_W-1:0]];
    end

    csq_entry_t rd_entry;
    assign rd_entry = rd_ok_reg ? rd_data_reg : '0;

    // Span test of the entry just read.
    logic signed [21:0] lba_x, span_lo, span_hi;
    logic               hit;
    assign lba_x   = $signed({{2{lba_reg[19]}}, lba_reg});
    assign span_lo = $signed({{2{rd_entry.start[19]}}, rd_entry.start}) -
                     $signed({3'd0, rd_entry.pregap});
    assign span_hi = $signed({{2{rd_entry.start[19]}}, rd_entry.start}) +
                     $signed({3'd0, rd_entry.length});
    assign hit     = rd_ok_reg && (lba_x >= span_lo) && (lba_x < span_hi);

    // Relation of the sector to the chosen entry.
    logic signed [21:0] start_x, end_x, diff, diff_mag, abs_x;
    logic               before_start, prev_swap;
    assign start_x      = $signed({{2{ent_reg.start[19]}}, ent_reg.start});
    assign end_x        = start_x + $signed({3'd0, ent_reg.length});
    assign diff         = lba_x - start_x;
    assign diff_mag     = diff[21] ? -diff : diff;
    assign abs_x        = lba_x + 22'(LEAD_IN_SECTORS);
    assign before_start = (lba_x < start_x);
    assign prev_swap    = (diff < -22'sd150) && ent_reg.control[2] &&
                          ({1'b0, cfg_val.base_track} < trk_reg) &&
                          !rd_entry.control[2];

    // Division by 75 or 60 by reciprocal multiplication: the quotient is registered
    // first and the remainder follows from it in the next cycle. Exact for all values that reach it.
    localparam logic [21:0] RECIP_75 = 22'd3579140;
    localparam logic [14:0] RECIP_60 = 15'd17477;
    logic [42:0]      prod_75;
    logic [28:0]      prod_60;
    logic [14:0]      quo_sel;
    logic [6:0]       divisor;
    logic [21:0]      quo_back;
    logic [REM_W-1:0] rem_calc;
    logic             div_done;
    assign prod_75  = {22'd0, num_reg} * {21'd0, RECIP_75};
    assign prod_60  = {15'd0, num_reg[13:0]} * {14'd0, RECIP_60};
    assign quo_sel  = step_reg[1] ? {6'd0, prod_60[28:20]} : prod_75[42:28];
    assign divisor  = step_reg[1] ? 7'(SECS_PER_MIN) : 7'(FRAMES_PER_SEC);
    assign quo_back = {7'd0, quo_reg} * {15'd0, divisor};
    assign rem_calc = num_reg[REM_W-1:0] - quo_back[REM_W-1:0];
    assign div_done = (step_reg == 3'd7);

    // Q frame byte selected by the beat counter.
    logic [7:0] q_sel;
    always_comb
    begin
        case (idx_reg)
            4'd0:    q_sel = {ctrl_reg, ADR_MODE1};
            4'd1:    q_sel = to_bcd(trk_reg);
            4'd2:    q_sel = {7'd0, index1_reg};
            4'd3:    q_sel = to_bcd(rel_m_reg);
            4'd4:    q_sel = to_bcd(rel_s_reg);
            4'd5:    q_sel = to_bcd(rel_f_reg);
            4'd6:    q_sel = 8'd0;
            4'd7:    q_sel = to_bcd(ab_m_reg);
            4'd8:    q_sel = to_bcd(ab_s_reg);
            4'd9:    q_sel = to_bcd(ab_f_reg);
            4'd10:   q_sel = ~crc_reg[15:8];
            4'd11:   q_sel = ~crc_reg[7:0];
            default: q_sel = 8'd0;
        endcase
    end

    // Interleave the Q bits with the pause bit.
    logic [63:0] sub_sel;
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            sub_sel[63-8*j -: 8] = (q_sel[7-j] ? SUB_Q : 8'd0) |
                                   (pause_reg ? SUB_PAUSE : 8'd0);
        end
    end

    assign out_load = !out_valid_reg || rsp.ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (head_valid && head_item.is_query)
                    state_next = ST_SCAN_RD;
            ST_SCAN_RD:
                state_next = (trk_reg < end_reg) ? ST_SCAN_CHK : ST_LOAD_RD;
            ST_SCAN_CHK:
                state_next = hit ? ST_PREV_RD : ST_SCAN_RD;
            ST_LOAD_RD:
                state_next = ST_LOAD_CHK;
            ST_LOAD_CHK:
                state_next = ST_PREV_RD;
            ST_PREV_RD:
                state_next = ST_PREV_CHK;
            ST_PREV_CHK:
                state_next = ST_DIV;
            ST_DIV:
                if (div_done)
                    state_next = ST_CRC;
            ST_CRC:
                if (idx_reg == 4'd9)
                    state_next = ST_EMIT;
            ST_EMIT:
                if (out_load && idx_reg == 4'(Q_BYTES - 1))
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Strobes decoded from the state.
    always_comb
    begin
        pop    = 1'b0;
        mem_we = 1'b0;
        rd_en  = 1'b0;
        rd_trk = trk_reg;
        case (state_reg)
            ST_IDLE:
            begin
                pop    = head_valid;
                mem_we = head_valid && !head_item.is_query && head_item.slot_ok;
            end
            ST_SCAN_RD:
                rd_en = 1'b1;
            ST_LOAD_RD:
                rd_en = 1'b1;
            ST_PREV_RD:
            begin
                rd_en  = 1'b1;
                rd_trk = trk_reg - 8'd1;
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
            found_reg     <= 1'b0;
            trk_reg       <= '0;
            end_reg       <= '0;
            step_reg      <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (rd_en)
                rd_ok_reg <= rd_in_range;

            case (state_reg)
                ST_IDLE:
                begin
                    trk_reg   <= {1'b0, cfg_val.base_track};
                    end_reg   <= {1'b0, cfg_val.base_track} + {1'b0, cfg_val.track_count};
                    found_reg <= 1'b0;
                end
                ST_SCAN_RD:
                    if (trk_reg >= end_reg)
                        trk_reg <= {1'b0, cfg_val.base_track};
                ST_SCAN_CHK:
                    if (hit)
                        found_reg <= 1'b1;
                    else
                        trk_reg <= trk_reg + 8'd1;
                ST_PREV_CHK:
                    step_reg <= '0;
                ST_DIV:
                begin
                    step_reg <= step_reg + 3'd1;
                    idx_reg  <= '0;
                end
                ST_CRC:
                    idx_reg <= (idx_reg == 4'd9) ? 4'd0 : idx_reg + 4'd1;
                ST_EMIT:
                    if (out_load)
                        idx_reg <= idx_reg + 4'd1;
                default: ;
            endcase

            if (state_reg == ST_EMIT && out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
                lba_reg <= head_item.lba;
            ST_SCAN_CHK:
                if (hit)
                    ent_reg <= rd_entry;
            ST_LOAD_CHK:
                ent_reg <= rd_entry;
            ST_PREV_CHK:
            begin
                ctrl_reg   <= prev_swap ? rd_entry.control : ent_reg.control;
                pause_reg  <= before_start || (lba_x >= end_x);
                index1_reg <= !before_start;
                num_reg    <= diff_mag[DIV_W-1:0];
                ab_reg     <= abs_x[21] ? '0 : abs_x[DIV_W-1:0];
            end
            ST_DIV:
            begin
                if (!step_reg[0])
                    quo_reg <= quo_sel;
                else
                begin
                    case (step_reg[2:1])
                        2'd0:
                        begin
                            rel_f_reg <= {1'b0, rem_calc};
                            num_reg   <= {6'd0, quo_reg};
                        end
                        2'd1:
                        begin
                            rel_s_reg <= {1'b0, rem_calc};
                            rel_m_reg <= quo_reg[7:0];
                            num_reg   <= ab_reg;
                        end
                        2'd2:
                        begin
                            ab_f_reg <= {1'b0, rem_calc};
                            num_reg  <= {6'd0, quo_reg};
                        end
                        default:
                        begin
                            ab_s_reg <= {1'b0, rem_calc};
                            ab_m_reg <= quo_reg[7:0];
                        end
                    endcase
                end
                crc_reg <= '0;
            end
            ST_CRC:
                crc_reg <= crc_byte(crc_reg, q_sel);
            ST_EMIT:
                if (out_load)
                begin
                    out_q_reg       <= q_sel;
                    out_sub_reg     <= sub_sel;
                    out_pause_reg   <= pause_reg;
                    out_missing_reg <= !found_reg;
                    out_last_reg    <= (idx_reg == 4'(Q_BYTES - 1));
                end
            default: ;
        endcase
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.q_byte        = out_q_reg;
    assign rsp.sub_bytes     = out_sub_reg;
    assign rsp.pause         = out_pause_reg;
    assign rsp.track_missing = out_missing_reg;
    assign rsp.last          = out_last_reg;

    // Checks on sequencing.
    `CSQ_ASSERT_IMP(a_pop_idle, pop, state_reg == ST_IDLE, "queue popped outside idle")
    `CSQ_ASSERT_IMP(a_rise_emit, $rose(out_valid_reg), state_reg == ST_EMIT, "response outside emit")
    `CSQ_ASSERT_IMP(a_idle_last, state_reg == ST_IDLE && out_valid_reg, out_last_reg, "idle with frame pending")
    `CSQ_ASSERT_NXT(a_emit_end, state_reg == ST_EMIT && out_load && idx_reg == 4'd11, out_last_reg && state_reg == ST_IDLE, "frame end lost")

endmodule

/* sv/cd_subcode_q_generator.sv */
// Top level of the CD subcode Q generator: front, queue and back.
// Depends on csq_pkg, csq_if, csq_front, csq_queue and csq_back.
//
//   Channel | Interface   | Carries
//   cfg     | csq_cfg_if  | register index, 7-bit data
//   req     | csq_req_if  | table write or sector query
//   rsp     | csq_rsp_if  | Q byte, subchannel bytes, flags, last
//
// A table write is stored in the cycle that it leaves the queue. A query
// scans the tracks with a registered table read of each, falls back to the
// first track when the scan misses, reads the previous track, then runs the
// reciprocal MSF division, the CRC over the first ten Q bytes and the 12
// output beats, each beat held while the response side stalls. Reset clears
// control state only: the two-entry queue is emptied, the track table kept.
module cd_subcode_q_generator
    import csq_pkg::*;
#(
    parameter int TRACK_SLOTS = TRACK_SLOTS_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    csq_cfg_if.sink cfg,
    csq_req_if.sink req,
    csq_rsp_if.source rsp
);

    csq_cfg_t  cfg_val;
    csq_item_t push_item;
    csq_item_t head_item;
    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      head_valid;

    // Accepts and classifies transactions.
    csq_front #(.TRACK_SLOTS(TRACK_SLOTS)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .req     (req),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (push_item),
        .cfg_val (cfg_val)
    );

    // Decouples the front from the back.
    csq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Executes table writes and queries.
    csq_back #(.TRACK_SLOTS(TRACK_SLOTS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_val    (cfg_val),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (q_pop),
        .rsp        (rsp)
    );

endmodule

/* sim/cd_subcode_q_generator_test.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the CD subcode Q generator: table writes, sector
// queries and register writes, checked beat by beat against a local predictor.
// Depends on csq_pkg, the csq channel interfaces and cd_subcode_q_generator.
module cd_subcode_q_generator_test;
    import csq_pkg::*;

    localparam int SLOTS       = 99;
    localparam int DRAIN_WAIT  = 450;
    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD   = 3000;
    localparam bit OP_WRITE    = 1'b0;
    localparam bit OP_QUERY    = 1'b1;

    typedef struct {
        logic [7:0]  q_byte;
        logic [63:0] sub_bytes;
        logic        pause;
        logic        track_missing;
        logic        last;
    } q_beat_t;

    logic clk;
    logic rst_n;

    csq_cfg_if cfg_ch ();
    csq_req_if req_ch ();
    csq_rsp_if rsp_ch ();

    cd_subcode_q_generator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Local copy of the registers and the track table.
    int      first_trk;
    int      trk_count;
    longint  trk_start [1:SLOTS];
    longint  trk_len [1:SLOTS];
    longint  trk_gap [1:SLOTS];
    int      trk_ctl [1:SLOTS];

    q_beat_t expected_beats[$];
    int      fail_count;
    int      send_idle_pct;
    int      recv_idle_pct;
    bit      hold_rsp;
    int      quiet_cycles = 0;

    // Clock.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Reads one table entry; numbers outside the table read as zero.
    function automatic void read_entry(input longint n, output longint s, output longint l,
                                       output longint g, output int c);
        if (n >= 1 && n <= SLOTS)
        begin
            s = trk_start[n];
            l = trk_len[n];
            g = trk_gap[n];
            c = trk_ctl[n];
        end
        else
        begin
            s = 0;
            l = 0;
            g = 0;
            c = 0;
        end
    endfunction

    function automatic logic [7:0] bcd_byte(input longint v);
        int b;
        b = int'(v & 255);
        return 8'((((b / 10) << 4) | (b % 10)) & 255);
    endfunction

    // Computes the twelve beats of a query and appends them to the store.
    function automatic void predict_q_frame(input logic [19:0] sector);
        longint     lba, trk, lim, s, l, g, rel, ab, ps, pl, pg;
        int         c, ctl, pc;
        bit         found;
        logic [7:0] q [12];
        logic [15:0] crc;
        logic [7:0] pause_bits;
        q_beat_t    beat;
        lba = longint'(signed'(sector));
        found = 1'b0;
        lim = first_trk + trk_count;
        for (trk = first_trk; trk < lim; trk++)
        begin
            if (trk < 1 || trk > SLOTS)
                continue;
            read_entry(trk, s, l, g, c);
            if (lba >= s - g && lba < s + l)
            begin
                found = 1'b1;
                break;
            end
        end
        if (!found)
            trk = first_trk;
        read_entry(trk, s, l, g, c);
        rel = lba - s;
        if (rel < 0)
            rel = -rel;
        ab = lba + 150;
        if (ab < 0)
            ab = 0;
        ctl = c;
        pause_bits = (lba < s || lba >= s + l) ? 8'h80 : 8'h00;
        // Audio before data: a deep pregap of a data track borrows the previous control.
        if (lba - s < -150 && (c & 4) != 0 && first_trk < trk)
        begin
            read_entry(trk - 1, ps, pl, pg, pc);
            if ((pc & 4) == 0)
                ctl = pc;
        end
        q[0] = 8'({ctl[3:0], 4'h1});
        q[1] = bcd_byte(trk);
        q[2] = (lba < s) ? 8'h00 : 8'h01;
        q[3] = bcd_byte(rel / 75 / 60);
        q[4] = bcd_byte((rel / 75) % 60);
        q[5] = bcd_byte(rel % 75);
        q[6] = 8'h00;
        q[7] = bcd_byte(ab / 75 / 60);
        q[8] = bcd_byte((ab / 75) % 60);
        q[9] = bcd_byte(ab % 75);
        crc = 16'h0000;
        for (int i = 0; i < 10; i++)
        begin
            crc = crc ^ {q[i], 8'h00};
            for (int k = 0; k < 8; k++)
                crc = crc[15] ? ({crc[14:0], 1'b0} ^ 16'h1021) : {crc[14:0], 1'b0};
        end
        crc = ~crc;
        q[10] = crc[15:8];
        q[11] = crc[7:0];
        for (int k = 0; k < 12; k++)
        begin
            beat.q_byte = q[k];
            beat.sub_bytes = 64'd0;
            for (int j = 0; j < 8; j++)
                beat.sub_bytes = {beat.sub_bytes[55:0],
                                  (q[k][7-j] ? 8'h40 : 8'h00) | pause_bits};
            beat.pause = (pause_bits != 8'h00);
            beat.track_missing = !found;
            beat.last = (k == 11);
            expected_beats.push_back(beat);
        end
    endfunction

    // Sends one request transaction and updates the predictor on acceptance.
    task automatic send_item(input bit op, input logic [6:0] tn, input logic [19:0] ts,
                             input logic [18:0] tl, input logic [18:0] pg,
                             input logic [3:0] tc, input logic [19:0] sa);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
        end
        @(negedge clk);
        req_ch.valid = 1'b1;
        req_ch.op = op;
        req_ch.track_number = tn;
        req_ch.track_start = ts;
        req_ch.track_length = tl;
        req_ch.pregap_length = pg;
        req_ch.track_control = tc;
        req_ch.sector_address = sa;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (op == OP_QUERY)
            predict_q_frame(sa);
        else if (tn >= 1 && tn <= SLOTS)
        begin
            trk_start[tn] = longint'(signed'(ts));
            trk_len[tn] = tl;
            trk_gap[tn] = pg;
            trk_ctl[tn] = tc;
        end
    endtask

    task automatic send_write(input logic [6:0] tn, input logic [19:0] ts,
                              input logic [18:0] tl, input logic [18:0] pg,
                              input logic [3:0] tc);
        send_item(OP_WRITE, tn, ts, tl, pg, tc, 20'($urandom));
    endtask

    task automatic send_query(input logic [19:0] sa);
        send_item(OP_QUERY, 7'($urandom), 20'($urandom), 19'($urandom), 19'($urandom),
                  4'($urandom), sa);
    endtask

    // Ends the request stream and waits for the block to be idle.
    task automatic wait_idle();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Writes one register; only called while the block is idle.
    task automatic write_reg(input logic [3:0] idx, input logic [6:0] value);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data = value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == CFG_BASE_TRACK)
            first_trk = value;
        else if (idx == CFG_TRACK_COUNT)
            trk_count = value;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_search(input int ft, input int cnt);
        write_reg(CFG_BASE_TRACK, 7'(ft));
        write_reg(CFG_TRACK_COUNT, 7'(cnt));
    endtask

    // Lays out all tracks back to back, audio and data mixed.
    task automatic load_disc_layout();
        longint pos, gap, len;
        pos = 0;
        for (int n = 1; n <= SLOTS; n++)
        begin
            gap = (n == 1) ? 150 : (($urandom_range(2) == 0) ? 0 : $urandom_range(400));
            len = $urandom_range(4000, 1);
            send_write(7'(n), 20'(pos + gap), 19'(len), 19'(gap), 4'($urandom));
            pos = pos + gap + len;
        end
        wait_idle();
    endtask

    // Picks a sector inside, or just around, a track of the searched range.
    task automatic send_track_query();
        int     hi, n;
        longint lo, span, sa;
        hi = first_trk + trk_count - 1;
        if (hi > SLOTS)
            hi = SLOTS;
        n = (hi >= first_trk) ? $urandom_range(hi, first_trk) : first_trk;
        lo = trk_start[n] - trk_gap[n];
        span = trk_gap[n] + trk_len[n];
        case ($urandom_range(9))
            0: sa = lo - 1;
            1: sa = trk_start[n] + trk_len[n];
            2: sa = trk_start[n];
            default: sa = lo + ((span > 0) ? longint'($urandom_range(32'(span - 1))) : 0);
        endcase
        send_query(20'(sa));
    endtask

    // Extremes of every field, ignored writes and each special case.
    task automatic test_directed_cases();
        set_search(1, SLOTS);
        send_query(20'sd0);
        send_query(-20'sd150);
        send_query(-20'sd151);
        send_query(20'h80000);
        send_query(20'h7FFFF);
        send_query(20'd449849);
        send_query(20'(trk_start[10]));
        send_query(20'(trk_start[10] + trk_len[10]));
        send_query(20'(trk_start[10] - 1));
        // Audio track followed by a data track with a long pregap.
        send_write(7'd20, 20'(trk_start[20]), 19'(trk_len[20]), 19'(trk_gap[20]), 4'h0);
        send_write(7'd21, 20'(trk_start[21]), 19'(trk_len[21]), 19'd600, 4'h4);
        send_query(20'(trk_start[21] - 400));
        send_query(20'(trk_start[21] - 100));
        // Writes to track numbers outside the table change nothing.
        send_write(7'd0, 20'h7FFFF, 19'h7FFFF, 19'h7FFFF, 4'hF);
        send_write(7'd127, 20'h80000, 19'h00000, 19'h00000, 4'h0);
        send_query(20'(trk_start[1]));
        // Field extremes held in the last slot.
        send_write(7'd99, 20'h80000, 19'h7FFFF, 19'h7FFFF, 4'hF);
        send_query(20'h80000);
        send_write(7'd99, 20'h7FFFF, 19'h00000, 19'h00000, 4'hB);
        send_query(20'h7FFFF);
        wait_idle();
        // Empty search falls back to the first track.
        set_search(1, 0);
        send_query(20'd1000);
        send_query(20'(trk_start[1]));
        wait_idle();
    endtask

    // Several register settings, the extremes among them.
    task automatic test_search_settings();
        int ft [5] = '{99, 99, 1, 50, 73};
        int cnt [5] = '{0, 99, 99, 20, 1};
        for (int i = 0; i < 5; i++)
        begin
            set_search(ft[i], cnt[i]);
            repeat (3) send_track_query();
            wait_idle();
        end
    endtask

    // Mostly well-formed queries, with noise writes and wild sectors.
    task automatic test_random_traffic(input int items, input int sidle, input int ridle);
        int r;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        set_search($urandom_range(99, 1), $urandom_range(99));
        for (int i = 0; i < items; i++)
        begin
            r = $urandom_range(9);
            if (r == 0)
                send_write(7'($urandom), 20'($urandom), 19'($urandom), 19'($urandom),
                           4'($urandom));
            else if (r == 1)
                send_query(20'($urandom));
            else
                send_track_query();
        end
        wait_idle();
    endtask

    // Receiver held off long enough to fill the block, then a full drain.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_search(1, 30);
        fork
            begin
                hold_rsp = 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_rsp = 1'b0;
            end
            repeat (8) send_track_query();
        join
        wait_idle();
        repeat (3) send_track_query();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (3) send_track_query();
        wait_idle();
    endtask

    // Receiver ready pattern.
    always @(negedge clk)
        rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);

    // Result checker.
    always @(posedge clk)
    begin
        q_beat_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("unexpected result transaction q_byte=%h", rsp_ch.q_byte);
                fail_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (rsp_ch.q_byte !== want.q_byte)
                begin
                    $error("q_byte: expected %h, got %h", want.q_byte, rsp_ch.q_byte);
                    fail_count++;
                end
                if (rsp_ch.sub_bytes !== want.sub_bytes)
                begin
                    $error("sub_bytes: expected %h, got %h", want.sub_bytes, rsp_ch.sub_bytes);
                    fail_count++;
                end
                if (rsp_ch.pause !== want.pause)
                begin
                    $error("pause: expected %b, got %b", want.pause, rsp_ch.pause);
                    fail_count++;
                end
                if (rsp_ch.track_missing !== want.track_missing)
                begin
                    $error("track_missing: expected %b, got %b", want.track_missing,
                           rsp_ch.track_missing);
                    fail_count++;
                end
                if (rsp_ch.last !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, rsp_ch.last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        rst_n = 1'b0;
        fail_count = 0;
        hold_rsp = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        first_trk = 1;
        trk_count = 0;
        req_ch.valid = 1'b0;
        req_ch.op = OP_WRITE;
        req_ch.track_number = '0;
        req_ch.track_start = '0;
        req_ch.track_length = '0;
        req_ch.pregap_length = '0;
        req_ch.track_control = '0;
        req_ch.sector_address = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_BASE_TRACK;
        cfg_ch.data = '0;
        rsp_ch.ready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        load_disc_layout();
        test_directed_cases();
        test_search_settings();
        test_random_traffic(5, 0, 0);
        test_random_traffic(5, 73, 0);
        test_random_traffic(5, 0, 73);
        test_random_traffic(5, 16, 16);
        test_backpressure();

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
